@@ rtl/core/bsws_pkg.sv @@
// ----------------------------------------------------------------------------
// bsws_pkg
// shared types and constants for the bounded byte stack with search
// ----------------------------------------------------------------------------
package bsws_pkg;

    localparam int DEPTH = 8;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        CMD_PUSH   = 2'd0,
        CMD_POP    = 2'd1,
        CMD_TOP    = 2'd2,
        CMD_SEARCH = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_OVERFLOW = 2'd1,
        ST_EMPTY    = 2'd2
    } t_status;

    typedef struct packed {
        t_cmd       cmd;
        logic [7:0] value;
    } t_in_item;

    typedef struct packed {
        t_status    status;
        logic [7:0] data;
        logic       found;
        logic [3:0] position;
        logic [3:0] count;
    } t_out_item;

    // controller to datapath
    typedef struct packed {
        logic    load;
        logic    push;
        logic    pop;
        logic    top;
        logic    search;
        logic    done;
        t_status status;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        t_cmd cmd;
        logic empty;
        logic full;
    } t_dp_stat;

endpackage

@@ rtl/core/bounded_stack_with_search_core.sv @@
// ----------------------------------------------------------------------------
// bounded_stack_with_search_core
// bounded lifo of bytes with push, pop, read top and search for lowest match
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+------------------------
//  in      | input     | i_in_valid / o_in_stall    | i_in_item  (cmd, value)
//  out     | output    | o_out_valid / i_out_stall  | o_out_item (status, data,
//          |           |                            |   found, position, count)
//
//  each transaction runs through capture, execute and present the result
//  the search compares all entries in parallel during the execute cycle
//  one transaction is in flight at a time; the next is taken once the result
//  has left the output register
//  i_rst_n is synchronous, active low, and empties the stack
//  a stalled result holds in the output register until i_out_stall drops
// ----------------------------------------------------------------------------
module bounded_stack_with_search_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  bsws_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output bsws_pkg::t_out_item o_out_item
);
    import bsws_pkg::*;

    // command and status between the sequencer and the datapath
    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    // sequencer: accepts a transaction when idle, runs it, holds the result
    bsws_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (dp_stat),
        .o_cmd       (dp_cmd)
    );

    // datapath: entry registers, fill count, comparators, result register
    bsws_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (i_in_item),
        .i_cmd   (dp_cmd),
        .o_stat  (dp_stat),
        .o_item  (o_out_item)
    );

endmodule

@@ rtl/core/bsws_ctrl.sv @@
// ----------------------------------------------------------------------------
// bsws_ctrl
// sequencer: capture a transaction, execute it, hold the result until taken
// ----------------------------------------------------------------------------
module bsws_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    input  bsws_pkg::t_dp_stat i_stat,
    output bsws_pkg::t_dp_cmd  o_cmd
);
    import bsws_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        o_cmd        = '0;
        o_cmd.status = ST_OK;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.done = 1'b1;
                n_state    = S_DONE;
                case (i_stat.cmd)
                    CMD_PUSH: begin
                        if (i_stat.full) o_cmd.status = ST_OVERFLOW;
                        else             o_cmd.push   = 1'b1;
                    end
                    CMD_POP: begin
                        if (i_stat.empty) o_cmd.status = ST_EMPTY;
                        else              o_cmd.pop    = 1'b1;
                    end
                    CMD_TOP: begin
                        if (i_stat.empty) o_cmd.status = ST_EMPTY;
                        else              o_cmd.top    = 1'b1;
                    end
                    default: begin
                        if (i_stat.empty) o_cmd.status = ST_EMPTY;
                        else              o_cmd.search = 1'b1;
                    end
                endcase
            end
            S_DONE: begin
                if (!i_out_stall) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = (r_state == S_DONE);

    // an accepted transaction always goes straight to execution
    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state == S_EXEC))
        else $error("accepted transaction did not enter execute");

    // a result is only written in the execute state, then shown next cycle
    a_done_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.done |=> o_out_valid)
        else $error("result not presented after execute");

endmodule

@@ rtl/core/bsws_dp.sv @@
// ----------------------------------------------------------------------------
// bsws_dp
// stack entries, fill count, parallel search and the result register
// ----------------------------------------------------------------------------
module bsws_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  bsws_pkg::t_in_item  i_item,
    input  bsws_pkg::t_dp_cmd   i_cmd,
    output bsws_pkg::t_dp_stat  o_stat,
    output bsws_pkg::t_out_item o_item
);
    import bsws_pkg::*;

    t_cmd             r_cmd;
    logic [7:0]       r_value;
    logic [7:0]       r_entries [DEPTH];
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    t_out_item        r_out;
    t_out_item        n_out;

    logic [CNT_W-1:0] top_ptr;
    logic [DEPTH-1:0] hits;
    logic             hit_any;
    logic [CNT_W-1:0] hit_pos;

    assign top_ptr = r_count - CNT_W'(1);

    // one comparator per entry, only live entries count
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            hits[i] = (r_entries[i] == r_value) && (CNT_W'(i) < r_count);
        end
    end

    // lowest matching entry wins
    always_comb begin
        hit_any = 1'b0;
        hit_pos = '0;
        for (int i = DEPTH - 1; i >= 0; i--) begin
            if (hits[i]) begin
                hit_any = 1'b1;
                hit_pos = CNT_W'(i + 1);
            end
        end
    end

    always_comb begin
        n_count = r_count;
        if (i_cmd.push)     n_count = r_count + CNT_W'(1);
        else if (i_cmd.pop) n_count = r_count - CNT_W'(1);
    end

    always_comb begin
        n_out          = '0;
        n_out.status   = i_cmd.status;
        n_out.data     = i_cmd.top ? r_entries[top_ptr[IDX_W-1:0]] : 8'd0;
        n_out.found    = i_cmd.search && hit_any;
        n_out.position = (i_cmd.search && hit_any) ? 4'(hit_pos) : 4'd0;
        n_out.count    = 4'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd   <= i_item.cmd;
            r_value <= i_item.value;
        end
        if (i_cmd.push) begin
            r_entries[r_count[IDX_W-1:0]] <= r_value;
        end
        if (i_cmd.done) begin
            r_out <= n_out;
        end
    end

    assign o_stat.cmd   = r_cmd;
    assign o_stat.empty = (r_count == '0);
    assign o_stat.full  = (r_count == CNT_W'(DEPTH));
    assign o_item       = r_out;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("fill count beyond depth");

    a_push_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.push |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("push did not grow the stack");

endmodule
